// ===== src/mgad_pkg.sv =====
package mgad_pkg;

  localparam int DW         = 32;
  localparam int DIFF_W     = DW + 1;
  localparam int PROD_W     = DW + DIFF_W;
  localparam int FRAC_BITS  = 16;
  localparam int TERM_W     = PROD_W - FRAC_BITS;
  localparam int SUM_W      = TERM_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0]  SIZE_X_RST = 8'd128;
  localparam logic [7:0]  SIZE_Y_RST = 8'd128;
  localparam logic [10:0] SIZE_Z_RST = 11'd1;
  localparam logic signed [DW-1:0] COEF_RST = -32'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 3'd0,
    CFG_SIZE_Y = 3'd1,
    CFG_SIZE_Z = 3'd2,
    CFG_COEF_X = 3'd3,
    CFG_COEF_Y = 3'd4,
    CFG_COEF_Z = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    CMD_VOXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef logic signed [DW-1:0] q16_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef struct packed {
    q16_t x;
    q16_t y;
    q16_t z;
    q16_t old;
    logic mask;
  } voxel_t;

  typedef struct packed {
    q16_t y;
    q16_t z;
    logic mask;
  } nbr_t;

  typedef struct packed {
    q16_t x;
    q16_t y;
    q16_t z;
  } coef_t;

  typedef struct packed {
    logic mask;
    q16_t old;
    logic last;
  } side_t;

  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t dz;
    side_t side;
  } arith_in_t;

endpackage

// ===== src/mgad_vox_if.sv =====
interface mgad_vox_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic signed [31:0] z_value;
  logic              in_mask;
  logic signed [31:0] old_result;

  modport source (
    output valid, cmd, x_value, y_value, z_value, in_mask, old_result,
    input  ready
  );
  modport sink (
    input  valid, cmd, x_value, y_value, z_value, in_mask, old_result,
    output ready
  );
endinterface

// ===== src/mgad_res_if.sv =====
interface mgad_res_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] result_value;
  logic              was_computed;
  logic              last_voxel;

  modport source (
    output valid, result_value, was_computed, last_voxel,
    input  ready
  );
  modport sink (
    input  valid, result_value, was_computed, last_voxel,
    output ready
  );
endinterface

// ===== src/mgad_arith.sv =====
module mgad_arith #(
  parameter int SAT_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mgad_pkg::coef_t     coef_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mgad_pkg::arith_in_t in_i,
  mgad_res_if.source          res
);
  import mgad_pkg::*;

  localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (SAT_BITS - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (SAT_BITS - 1));
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

  logic s2_v_q, s3_v_q, s4_v_q, o_v_q;
  logic rdy3, rdy4, rdy_o;

  arith_in_t s2_q;
  logic signed [PROD_W-1:0] px_q, py_q, pz_q;
  side_t s3_side_q, s4_side_q;
  logic signed [TERM_W-1:0] tx_q, ty_q, tz_q;

  logic signed [PROD_W-1:0] px_d, py_d, pz_d;
  logic signed [PROD_W-1:0] rx, ry, rz;
  logic signed [SUM_W-1:0] sum;
  q16_t sat;

  logic signed [31:0] val_q;
  logic               comp_q, last_q;

  assign rdy_o      = !o_v_q || res.ready;
  assign rdy4       = !s4_v_q || rdy_o;
  assign rdy3       = !s3_v_q || rdy4;
  assign in_ready_o = !s2_v_q || rdy3;

  always_comb begin
    px_d = PROD_W'(coef_i.x) * PROD_W'(s2_q.dx);
    py_d = PROD_W'(coef_i.y) * PROD_W'(s2_q.dy);
    pz_d = PROD_W'(coef_i.z) * PROD_W'(s2_q.dz);
    rx   = px_q + HALF;
    ry   = py_q + HALF;
    rz   = pz_q + HALF;
    sum  = SUM_W'(tx_q) + SUM_W'(ty_q) + SUM_W'(tz_q);
    if (sum > SAT_HI) begin
      sat = DW'(SAT_HI);
    end else if (sum < SAT_LO) begin
      sat = DW'(SAT_LO);
    end else begin
      sat = DW'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (in_ready_o) s2_v_q <= in_valid_i;
      if (rdy3) s3_v_q <= s2_v_q;
      if (rdy4) s4_v_q <= s3_v_q;
      if (rdy_o) o_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) s2_q <= in_i;
    if (rdy3 && s2_v_q) begin
      px_q      <= px_d;
      py_q      <= py_d;
      pz_q      <= pz_d;
      s3_side_q <= s2_q.side;
    end
    if (rdy4 && s3_v_q) begin
      tx_q      <= rx[PROD_W-1:FRAC_BITS];
      ty_q      <= ry[PROD_W-1:FRAC_BITS];
      tz_q      <= rz[PROD_W-1:FRAC_BITS];
      s4_side_q <= s3_side_q;
    end
    if (rdy_o && s4_v_q) begin
      val_q  <= s4_side_q.mask ? sat : s4_side_q.old;
      comp_q <= s4_side_q.mask;
      last_q <= s4_side_q.last;
    end
  end

  assign res.valid        = o_v_q;
  assign res.result_value = val_q;
  assign res.was_computed = comp_q;
  assign res.last_voxel   = last_q;

endmodule

// ===== src/masked_3d_gradient_adjoint.sv =====
// masked divergence over a streamed 3d volume
// vox_i carries voxels in raster order, x fastest, then flush items (cmd 1)
// after the last voxel; res_o carries one result item per voxel, in order
// cfg port sets sizes and per-axis coefficients; the user must write it
// only while the block is idle, which the block itself does not enforce;
// a voxel's result is released by the arrival of the voxel one plane later
// (size_x * size_y items), or by a flush item once the volume is complete;
// throughput is one item per cycle while res_o does not stall: two window
// memories of 2*MAX_ROW*MAX_ROWS+1 entries each give two reads and one
// write per cycle, the current voxel's own neighbors come from forwarding
// and history regs; the window memories need no clearing pass; reset clears
// counters, loads default sizes and coefficients, and the block accepts
// items right after reset; when res_o stalls, items keep entering until the
// five pipeline stages are full, then vox_i.ready drops
module masked_3d_gradient_adjoint #(
  parameter int MAX_ROW    = 128,
  parameter int MAX_ROWS   = 128,
  parameter int MAX_PLANES = 1024,
  parameter int DATA_BITS  = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mgad_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mgad_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mgad_vox_if.sink                        vox_i,
  mgad_res_if.source                      res_o
);
  import mgad_pkg::*;

  localparam int XW        = $clog2(MAX_ROW + 1);
  localparam int YW        = $clog2(MAX_ROWS + 1);
  localparam int ZW        = $clog2(MAX_PLANES + 1);
  localparam int PLANE_MAX = MAX_ROW * MAX_ROWS;
  localparam int PW        = $clog2(PLANE_MAX + 1);
  localparam int DEPTH     = 2 * PLANE_MAX + 1;
  localparam int AW        = $clog2(DEPTH);
  localparam longint TOT_MAX = longint'(PLANE_MAX) * longint'(MAX_PLANES);
  localparam int CW        = $clog2(TOT_MAX + 1);
  localparam int SAT_BITS  = (DATA_BITS < 32) ? DATA_BITS : 32;

  typedef struct packed {
    logic first;
    logic xp;
    logic xn;
    logic yp;
    logic yn;
    logic zp;
    logic zn;
    logic last;
  } nb_t;

  function automatic logic [XW-1:0] clamp_x(logic [7:0] v);
    if (v == 8'd0) return XW'(1);
    else if (int'(v) > MAX_ROW) return XW'(MAX_ROW);
    else return XW'(v);
  endfunction

  function automatic logic [YW-1:0] clamp_y(logic [7:0] v);
    if (v == 8'd0) return YW'(1);
    else if (int'(v) > MAX_ROWS) return YW'(MAX_ROWS);
    else return YW'(v);
  endfunction

  function automatic logic [ZW-1:0] clamp_z(logic [10:0] v);
    if (v == 11'd0) return ZW'(1);
    else if (int'(v) > MAX_PLANES) return ZW'(MAX_PLANES);
    else return ZW'(v);
  endfunction

  function automatic logic [PW-1:0] mul_plane(logic [XW-1:0] a, logic [YW-1:0] b);
    logic [XW+YW-1:0] p;
    p = (XW + YW)'(a) * (XW + YW)'(b);
    return PW'(p);
  endfunction

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [PW-1:0] off);
    logic [AW:0] s;
    s = (AW + 1)'(a) + (AW + 1)'(off);
    if (s >= (AW + 1)'(DEPTH)) s = s - (AW + 1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] wrap_sub(logic [AW-1:0] a, logic [PW-1:0] off);
    logic [AW:0] s;
    s = (AW + 1)'(a) + (AW + 1)'(DEPTH) - (AW + 1)'(off);
    if (s >= (AW + 1)'(DEPTH)) s = s - (AW + 1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic diff_t dif(q16_t hi, q16_t lo);
    return DIFF_W'(hi) - DIFF_W'(lo);
  endfunction

  // configuration
  logic [XW-1:0] nx_q;
  logic [YW-1:0] ny_q;
  logic [ZW-1:0] nz_q;
  logic [PW-1:0] plane_q;
  coef_t         coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q    <= clamp_x(SIZE_X_RST);
      ny_q    <= clamp_y(SIZE_Y_RST);
      nz_q    <= clamp_z(SIZE_Z_RST);
      plane_q <= mul_plane(clamp_x(SIZE_X_RST), clamp_y(SIZE_Y_RST));
      coef_q  <= '{x: COEF_RST, y: COEF_RST, z: COEF_RST};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SIZE_X: begin
          nx_q    <= clamp_x(cfg_data_i[7:0]);
          plane_q <= mul_plane(clamp_x(cfg_data_i[7:0]), ny_q);
        end
        CFG_SIZE_Y: begin
          ny_q    <= clamp_y(cfg_data_i[7:0]);
          plane_q <= mul_plane(nx_q, clamp_y(cfg_data_i[7:0]));
        end
        CFG_SIZE_Z: nz_q <= clamp_z(cfg_data_i[10:0]);
        CFG_COEF_X: coef_q.x <= q16_t'(cfg_data_i);
        CFG_COEF_Y: coef_q.y <= q16_t'(cfg_data_i);
        CFG_COEF_Z: coef_q.z <= q16_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // counters and control
  logic [CW-1:0] rec_q, emit_q, total;
  logic [CW:0]   lead;
  logic [AW-1:0] wp_q, ep_q;
  logic [XW-1:0] i_q;
  logic [YW-1:0] j_q;
  logic [ZW-1:0] k_q;
  logic acc, is_vox, room, ahead, wr, give, last;
  logic s1_rdy, ar_rdy;
  logic [AW-1:0] a_nx, a_yn, a_yp, a_zp;
  voxel_t in_rec;
  nb_t    nb;

  assign acc    = vox_i.valid && vox_i.ready;
  assign is_vox = cmd_e'(vox_i.cmd) == CMD_VOXEL;

  always_comb begin
    total = CW'((PW + ZW)'(plane_q) * (PW + ZW)'(nz_q));
    lead  = (CW + 1)'(emit_q) + (CW + 1)'(plane_q);
    room  = rec_q < total;
    ahead = lead <= (CW + 1)'(rec_q);
    wr    = acc && is_vox && room;
    give  = acc && (is_vox ? (room && ahead) : (!room && (emit_q < rec_q)));
    last  = (i_q == nx_q - XW'(1)) && (j_q == ny_q - YW'(1)) && (k_q == nz_q - ZW'(1));
    a_nx  = wrap_add(ep_q, PW'(1));
    a_yn  = wrap_add(ep_q, PW'(nx_q));
    a_yp  = wrap_sub(ep_q, PW'(nx_q));
    a_zp  = wrap_sub(ep_q, plane_q);
    in_rec = '{x: vox_i.x_value, y: vox_i.y_value, z: vox_i.z_value,
               old: vox_i.old_result, mask: vox_i.in_mask};
    nb.first = (emit_q == '0);
    nb.xp    = (i_q != '0);
    nb.xn    = (i_q != nx_q - XW'(1));
    nb.yp    = (j_q != '0);
    nb.yn    = (j_q != ny_q - YW'(1));
    nb.zp    = (k_q != '0);
    nb.zn    = (k_q != nz_q - ZW'(1)) && is_vox;
    nb.last  = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q  <= '0;
      emit_q <= '0;
      wp_q   <= '0;
      ep_q   <= '0;
      i_q    <= '0;
      j_q    <= '0;
      k_q    <= '0;
    end else begin
      if (wr) begin
        rec_q <= rec_q + CW'(1);
        wp_q  <= wrap_add(wp_q, PW'(1));
      end
      if (give) begin
        if (last) begin
          rec_q  <= '0;
          emit_q <= '0;
          wp_q   <= '0;
          ep_q   <= '0;
          i_q    <= '0;
          j_q    <= '0;
          k_q    <= '0;
        end else begin
          emit_q <= emit_q + CW'(1);
          ep_q   <= a_nx;
          if (!nb.xn) begin
            i_q <= '0;
            if (!nb.yn) begin
              j_q <= '0;
              k_q <= k_q + ZW'(1);
            end else begin
              j_q <= j_q + YW'(1);
            end
          end else begin
            i_q <= i_q + XW'(1);
          end
        end
      end
    end
  end

  // window memories
  voxel_t mem_a [DEPTH];
  nbr_t   mem_b [DEPTH];
  voxel_t rd_a1_q, rd_a2_q;
  nbr_t   rd_b1_q, rd_b2_q;

  always_ff @(posedge clk_i) begin
    if (wr) mem_a[wp_q] <= in_rec;
    if (give) begin
      rd_a1_q <= mem_a[a_nx];
      rd_a2_q <= mem_a[a_yn];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_b[wp_q] <= '{y: in_rec.y, z: in_rec.z, mask: in_rec.mask};
    if (give) begin
      rd_b1_q <= mem_b[a_yp];
      rd_b2_q <= mem_b[a_zp];
    end
  end

  // read stage
  logic   s1_v_q, fa1_q, fa2_q;
  voxel_t s1_in_q, first_q, hist_q, hist2_q;
  nb_t    s1_nb_q;
  voxel_t nxt, yn, cen;
  arith_in_t ar_in;

  assign s1_rdy      = !s1_v_q || ar_rdy;
  assign vox_i.ready = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= give;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr && (rec_q == '0)) first_q <= in_rec;
    if (give) begin
      s1_in_q <= in_rec;
      s1_nb_q <= nb;
      fa1_q   <= wr && (a_nx == wp_q);
      fa2_q   <= wr && (a_yn == wp_q);
    end
    if (s1_v_q && ar_rdy) begin
      hist_q  <= nxt;
      hist2_q <= cen;
    end
  end

  always_comb begin
    nxt = fa1_q ? s1_in_q : rd_a1_q;
    yn  = fa2_q ? s1_in_q : rd_a2_q;
    cen = s1_nb_q.first ? first_q : hist_q;

    if (s1_nb_q.xp && hist2_q.mask) ar_in.dx = dif(cen.x, hist2_q.x);
    else if (s1_nb_q.xn && nxt.mask) ar_in.dx = dif(nxt.x, cen.x);
    else ar_in.dx = '0;

    if (s1_nb_q.yp && rd_b1_q.mask) ar_in.dy = dif(cen.y, rd_b1_q.y);
    else if (s1_nb_q.yn && yn.mask) ar_in.dy = dif(yn.y, cen.y);
    else ar_in.dy = '0;

    if (s1_nb_q.zp && rd_b2_q.mask) ar_in.dz = dif(cen.z, rd_b2_q.z);
    else if (s1_nb_q.zn && s1_in_q.mask) ar_in.dz = dif(s1_in_q.z, cen.z);
    else ar_in.dz = '0;

    ar_in.side = '{mask: cen.mask, old: cen.old, last: s1_nb_q.last};
  end

  mgad_arith #(
    .SAT_BITS(SAT_BITS)
  ) u_arith (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .coef_i    (coef_q),
    .in_valid_i(s1_v_q),
    .in_ready_o(ar_rdy),
    .in_i      (ar_in),
    .res       (res_o)
  );

endmodule

// ===== src/mgad_chk.sv =====
module mgad_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic        out_computed,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_computed) &&
    $stable(out_last))
    else $error("stalled result item changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid)
    else $error("result valid during reset");

endmodule

bind masked_3d_gradient_adjoint mgad_chk u_mgad_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (vox_i.valid),
  .in_ready    (vox_i.ready),
  .out_valid   (res_o.valid),
  .out_ready   (res_o.ready),
  .out_value   (res_o.result_value),
  .out_computed(res_o.was_computed),
  .out_last    (res_o.last_voxel)
);

// ===== tb/masked_3d_gradient_adjoint_tb.sv =====
module masked_3d_gradient_adjoint_tb;
  import mgad_pkg::*;

  localparam int WIN = 2 * 128 * 128 + 1;

  typedef struct {
    cmd_e cmd;
    q16_t x;
    q16_t y;
    q16_t z;
    logic mask;
    q16_t old;
  } vox_item_t;

  typedef struct {
    q16_t value;
    logic computed;
    logic last;
  } div_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mgad_vox_if vox_bus ();
  mgad_res_if res_bus ();

  masked_3d_gradient_adjoint i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .vox_i     (vox_bus),
    .res_o     (res_bus)
  );

  // shadow of the block
  int wx[WIN];
  int wy[WIN];
  int wz[WIN];
  int wold[WIN];
  bit wmask[WIN];
  longint unsigned n_recv;
  longint unsigned n_emit;
  logic [7:0] sh_size_x;
  logic [7:0] sh_size_y;
  logic [10:0] sh_size_z;
  longint sh_coef_x;
  longint sh_coef_y;
  longint sh_coef_z;

  vox_item_t pending_voxels[$];
  div_result_t expected_divs[$];

  int mismatches;
  int items_in;
  int results_out;
  int volumes_done;
  int burst_left;
  int gap_left;
  int hold_left;
  bit hold_req;
  int mode;
  int mode_left;

  function automatic longint clamp_size(longint v, longint hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint win_val(int axis, longint unsigned idx);
    int s;
    s = int'(idx % WIN);
    case (axis)
      0: return longint'(wx[s]);
      1: return longint'(wy[s]);
      default: return longint'(wz[s]);
    endcase
  endfunction

  function automatic longint scaled_diff(longint c, longint hi, longint lo);
    longint p;
    p = c * (hi - lo);
    return (p + 32768) >>> 16;
  endfunction

  function automatic longint axis_term(int axis, longint c, longint unsigned l,
                                       longint unsigned stride, bit hp, bit hn);
    longint here;
    here = win_val(axis, l);
    if (hp && wmask[int'((l - stride) % WIN)])
      return scaled_diff(c, here, win_val(axis, l - stride));
    if (hn && wmask[int'((l + stride) % WIN)])
      return scaled_diff(c, win_val(axis, l + stride), here);
    return 0;
  endfunction

  task automatic divergence_step(vox_item_t it);
    longint unsigned nx, ny, nz, plane, total, i, j, k;
    longint sum;
    bit give;
    int s;
    div_result_t r;
    nx = clamp_size(sh_size_x, 128);
    ny = clamp_size(sh_size_y, 128);
    nz = clamp_size(sh_size_z, 1024);
    plane = nx * ny;
    total = plane * nz;
    give = 0;
    if (n_emit >= total) begin
      n_emit = 0;
      n_recv = 0;
    end
    if (it.cmd == CMD_VOXEL) begin
      if (n_recv < total) begin
        s = int'(n_recv % WIN);
        wx[s] = it.x;
        wy[s] = it.y;
        wz[s] = it.z;
        wmask[s] = it.mask;
        wold[s] = it.old;
        n_recv++;
        if (n_emit + plane < n_recv) give = 1;
      end
    end else if (n_recv >= total && n_emit < n_recv) begin
      give = 1;
    end
    if (!give) return;
    s = int'(n_emit % WIN);
    i = n_emit % nx;
    j = (n_emit / nx) % ny;
    k = n_emit / plane;
    if (wmask[s]) begin
      sum = axis_term(2, sh_coef_z, n_emit, plane, k > 0, k + 1 < nz);
      sum += axis_term(1, sh_coef_y, n_emit, nx, j > 0, j + 1 < ny);
      sum += axis_term(0, sh_coef_x, n_emit, 1, i > 0, i + 1 < nx);
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      r.value = q16_t'(sum);
      r.computed = 1'b1;
    end else begin
      r.value = wold[s];
      r.computed = 1'b0;
    end
    r.last = (n_emit + 1 == total);
    expected_divs.push_back(r);
    n_emit++;
    if (n_emit >= total) begin
      n_emit = 0;
      n_recv = 0;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    vox_bus.valid = 1'b0;
    vox_bus.cmd = CMD_VOXEL;
    vox_bus.x_value = '0;
    vox_bus.y_value = '0;
    vox_bus.z_value = '0;
    vox_bus.in_mask = 1'b0;
    vox_bus.old_result = '0;
    res_bus.ready = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // sender: bursts with gaps
  always @(posedge clk_i) begin
    vox_item_t it;
    if (!rst_ni) begin
      vox_bus.valid <= 1'b0;
    end else if (!vox_bus.valid || vox_bus.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        vox_bus.valid <= 1'b0;
      end else if (pending_voxels.size() != 0) begin
        it = pending_voxels.pop_front();
        vox_bus.cmd <= it.cmd;
        vox_bus.x_value <= it.x;
        vox_bus.y_value <= it.y;
        vox_bus.z_value <= it.z;
        vox_bus.in_mask <= it.mask;
        vox_bus.old_result <= it.old;
        vox_bus.valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        vox_bus.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern plus one long hold
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = 300;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 120);
        end else begin
          mode_left--;
        end
        case (mode)
          0: res_bus.ready <= 1'b1;
          1: res_bus.ready <= $urandom_range(0, 1);
          default: res_bus.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    vox_item_t it;
    div_result_t e;
    if (rst_ni) begin
      if (vox_bus.valid && vox_bus.ready) begin
        it.cmd = cmd_e'(vox_bus.cmd);
        it.x = vox_bus.x_value;
        it.y = vox_bus.y_value;
        it.z = vox_bus.z_value;
        it.mask = vox_bus.in_mask;
        it.old = vox_bus.old_result;
        items_in++;
        divergence_step(it);
      end
      if (res_bus.valid && res_bus.ready) begin
        results_out++;
        if (expected_divs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item: value %h computed %b last %b",
                     res_bus.result_value, res_bus.was_computed, res_bus.last_voxel);
        end else begin
          e = expected_divs.pop_front();
          if (res_bus.result_value !== e.value || res_bus.was_computed !== e.computed ||
              res_bus.last_voxel !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h/%b/%b got %h/%b/%b", e.value, e.computed,
                       e.last, res_bus.result_value, res_bus.was_computed,
                       res_bus.last_voxel);
          end
        end
      end
    end
  end

  function automatic q16_t pick_val();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      4: return q16_t'($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
      default: return q16_t'($urandom);
    endcase
  endfunction

  function automatic q16_t pick_coef();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return COEF_RST;
      3: return '0;
      default: return q16_t'($urandom);
    endcase
  endfunction

  function automatic vox_item_t make_voxel(cmd_e c);
    vox_item_t it;
    it.cmd = c;
    it.x = pick_val();
    it.y = pick_val();
    it.z = pick_val();
    it.old = pick_val();
    it.mask = ($urandom_range(0, 9) < 7);
    return it;
  endfunction

  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_voxels.size() != 0 || vox_bus.valid || expected_divs.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_SIZE_X: sh_size_x = data[7:0];
      CFG_SIZE_Y: sh_size_y = data[7:0];
      CFG_SIZE_Z: sh_size_z = data[10:0];
      CFG_COEF_X: sh_coef_x = longint'(q16_t'(data));
      CFG_COEF_Y: sh_coef_y = longint'(q16_t'(data));
      default: sh_coef_z = longint'(q16_t'(data));
    endcase
  endtask

  task automatic run_volume(int sx, int sy, int sz, q16_t cx, q16_t cy, q16_t cz,
                            bit noise, bit long_hold);
    longint total, plane;
    wait_idle();
    write_reg(CFG_SIZE_X, sx);
    write_reg(CFG_SIZE_Y, sy);
    write_reg(CFG_SIZE_Z, sz);
    write_reg(CFG_COEF_X, cx);
    write_reg(CFG_COEF_Y, cy);
    write_reg(CFG_COEF_Z, cz);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    plane = clamp_size(sx, 128) * clamp_size(sy, 128);
    total = plane * clamp_size(sz, 1024);
    if (long_hold) hold_req = 1;
    for (longint n = 0; n < total; n++) begin
      // early flush gives nothing
      if (noise && $urandom_range(0, 19) == 0)
        pending_voxels.push_back(make_voxel(CMD_FLUSH));
      pending_voxels.push_back(make_voxel(CMD_VOXEL));
    end
    // voxel past a complete volume is dropped
    if (noise) pending_voxels.push_back(make_voxel(CMD_VOXEL));
    for (longint n = 0; n < plane; n++)
      pending_voxels.push_back(make_voxel(CMD_FLUSH));
    if (noise) pending_voxels.push_back(make_voxel(CMD_FLUSH));
    volumes_done++;
  endtask

  initial begin
    int sent;
    int sx, sy, sz;
    sh_size_x = SIZE_X_RST;
    sh_size_y = SIZE_Y_RST;
    sh_size_z = SIZE_Z_RST;
    sh_coef_x = COEF_RST;
    sh_coef_y = COEF_RST;
    sh_coef_z = COEF_RST;
    @(posedge rst_ni);
    // directed volumes
    run_volume(3, 2, 2, 32'sh7fff_ffff, 32'sh8000_0000, COEF_RST, 1, 0);
    run_volume(0, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 1, 0);
    // oversized row, clamped to the maximum
    run_volume(255, 1, 1, pick_coef(), pick_coef(), pick_coef(), 0, 0);
    // random volumes
    sent = 0;
    while (sent < 60) begin
      case ($urandom_range(0, 9))
        0: begin sx = 1; sy = $urandom_range(0, 12); sz = $urandom_range(0, 3); end
        default: begin
          sx = $urandom_range(0, 6);
          sy = $urandom_range(0, 5);
          sz = $urandom_range(0, 4);
        end
      endcase
      run_volume(sx, sy, sz, pick_coef(), pick_coef(), pick_coef(),
                 $urandom_range(0, 3) == 0, 0);
      sent += int'(clamp_size(sx, 128) * clamp_size(sy, 128) *
                   (clamp_size(sz, 1024) + 1));
    end
    // long receiver hold while the sender keeps offering
    run_volume(4, 3, 2, pick_coef(), pick_coef(), pick_coef(), 0, 1);
    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("%0d volumes streamed, %0d items accepted, %0d results checked",
             volumes_done, items_in, results_out);
    if (mismatches == 0 && expected_divs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_divs.size());
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end

endmodule
